// ===== src/rth_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSL converter.
package rth_pkg;

   localparam int CHAN_W     = 8;
   localparam int NUM_W      = 24;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = NUM_W / DIV_STEPS;

   localparam logic [14:0] HUE_MAX        = 15'd23040;
   localparam logic [14:0] HUE_BASE_RED   = 15'd0;
   localparam logic [14:0] HUE_BASE_WRAP  = 15'd23040;
   localparam logic [14:0] HUE_BASE_GREEN = 15'd7680;
   localparam logic [14:0] HUE_BASE_BLUE  = 15'd15360;
   localparam logic [11:0] DEG60          = 12'd3840;
   localparam logic [12:0] PCT_MAX        = 13'd6400;
   localparam logic [12:0] SAT_SCALE      = 13'd6400;
   localparam logic [11:0] LIT_SCALE      = 12'd3200;
   localparam logic [CHAN_W-1:0] LIT_DIV  = 8'd255;
   localparam logic [CHAN_W:0]   SUM_HALF = 9'd255;
   localparam logic [CHAN_W+1:0] SUM_FULL = 10'd510;

   // 3200*sum/255 as (sum * LIT_RECIP) >> LIT_SHIFT, exact for sum up to 510
   localparam logic [21:0] LIT_RECIP = 22'd3289651;
   localparam int          LIT_SHIFT = 18;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [12:0] saturation;
      logic [12:0] lightness;
   } hsl_type;

   typedef struct packed {
      logic                     valid;
      logic [CHAN_W-1:0]        delta;
      logic [CHAN_W:0]          sum;
      logic [14:0]              base;
      logic signed [CHAN_W:0]   diff;
   } span_type;

   typedef struct packed {
      logic              valid;
      logic              grey;
      logic [NUM_W-1:0]  hue_num;
      logic [CHAN_W-1:0] hue_den;
      logic [NUM_W-1:0]  sat_num;
      logic [CHAN_W-1:0] sat_den;
      logic [12:0]       lit;
   } ratio_type;

   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  quo;
      logic [CHAN_W-1:0] den;
   } div_stage_type;

   // one restoring division step: one quotient bit
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type     r;
      logic [CHAN_W:0]   t;
      logic              q;
      t = {s.rem, s.num[NUM_W-1]};
      if (t >= {1'b0, s.den}) begin
         r.rem = CHAN_W'(t - {1'b0, s.den});
         q     = 1'b1;
      end else begin
         r.rem = t[CHAN_W-1:0];
         q     = 1'b0;
      end
      r.num = {s.num[NUM_W-2:0], 1'b0};
      r.quo = {s.quo[NUM_W-2:0], q};
      r.den = s.den;
      return r;
   endfunction

endpackage

// ===== src/rth_front.sv =====
// Front end: channel max/min, hue sector, division operands and lightness, two stages.
module rth_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rth_pkg::pixel_type   pixel,
   output rth_pkg::ratio_type   ratio
);

   rth_pkg::span_type  span_in, span_ff;
   rth_pkg::ratio_type ratio_in, ratio_ff;

   logic [rth_pkg::CHAN_W-1:0] mx, mn;
   logic [22:0]                base_prod;
   logic signed [21:0]         diff_prod;
   logic signed [24:0]         hue_total;
   logic [30:0]                lit_prod;

   // stage 1: extremes and sector
   always_comb begin
      mx = pixel.red;
      mn = pixel.red;
      if (pixel.green > mx) mx = pixel.green;
      if (pixel.blue > mx)  mx = pixel.blue;
      if (pixel.green < mn) mn = pixel.green;
      if (pixel.blue < mn)  mn = pixel.blue;
      span_in.valid = in_valid;
      span_in.delta = mx - mn;
      span_in.sum   = {1'b0, mx} + {1'b0, mn};
      if (mx == pixel.red) begin
         span_in.base = (pixel.green >= pixel.blue) ? rth_pkg::HUE_BASE_RED
                                                    : rth_pkg::HUE_BASE_WRAP;
         span_in.diff = {1'b0, pixel.green} - {1'b0, pixel.blue};
      end else if (mx == pixel.green) begin
         span_in.base = rth_pkg::HUE_BASE_GREEN;
         span_in.diff = {1'b0, pixel.blue} - {1'b0, pixel.red};
      end else begin
         span_in.base = rth_pkg::HUE_BASE_BLUE;
         span_in.diff = {1'b0, pixel.red} - {1'b0, pixel.green};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff.valid <= 1'b0;
      end else begin
         span_ff.valid <= span_in.valid;
      end
      span_ff.delta <= span_in.delta;
      span_ff.sum   <= span_in.sum;
      span_ff.base  <= span_in.base;
      span_ff.diff  <= span_in.diff;
   end

   // stage 2: numerators, divisors and lightness
   always_comb begin
      base_prod = 23'(span_ff.base) * 23'(span_ff.delta);
      diff_prod = 22'(span_ff.diff) * $signed({10'd0, rth_pkg::DEG60});
      hue_total = $signed({2'b00, base_prod}) + 25'(diff_prod);
      lit_prod  = 31'(span_ff.sum) * 31'(rth_pkg::LIT_RECIP);

      ratio_in.valid   = span_ff.valid;
      ratio_in.grey    = (span_ff.delta == '0);
      ratio_in.hue_num = hue_total[24] ? '0 : rth_pkg::NUM_W'(hue_total[23:0]);
      ratio_in.hue_den = span_ff.delta;
      ratio_in.sat_num = rth_pkg::NUM_W'(span_ff.delta) * rth_pkg::NUM_W'(rth_pkg::SAT_SCALE);
      ratio_in.sat_den = (span_ff.sum <= rth_pkg::SUM_HALF)
                         ? span_ff.sum[rth_pkg::CHAN_W-1:0]
                         : rth_pkg::CHAN_W'(rth_pkg::SUM_FULL - {1'b0, span_ff.sum});
      ratio_in.lit     = lit_prod[rth_pkg::LIT_SHIFT +: 13];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff.valid <= 1'b0;
      end else begin
         ratio_ff.valid <= ratio_in.valid;
      end
      ratio_ff.grey    <= ratio_in.grey;
      ratio_ff.hue_num <= ratio_in.hue_num;
      ratio_ff.hue_den <= ratio_in.hue_den;
      ratio_ff.sat_num <= ratio_in.sat_num;
      ratio_ff.sat_den <= ratio_in.sat_den;
      ratio_ff.lit     <= ratio_in.lit;
   end

   assign ratio = ratio_ff;

endmodule

// ===== src/rth_div.sv =====
// Pipelined restoring divider, four quotient bits per stage.
module rth_div (
   input  logic                          clock,
   input  logic [rth_pkg::NUM_W-1:0]     num,
   input  logic [rth_pkg::CHAN_W-1:0]    den,
   output logic [rth_pkg::NUM_W-1:0]     quo
);

   rth_pkg::div_stage_type src   [rth_pkg::DIV_STAGES];
   rth_pkg::div_stage_type stage_in [rth_pkg::DIV_STAGES];
   rth_pkg::div_stage_type stage_ff [rth_pkg::DIV_STAGES];

   for (genvar i = 0; i < rth_pkg::DIV_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign src[i] = '{rem: '0, num: num, quo: '0, den: den};
      end else begin : g_next
         assign src[i] = stage_ff[i-1];
      end

      always_comb begin
         rth_pkg::div_stage_type s;
         s = src[i];
         for (int k = 0; k < rth_pkg::DIV_STEPS; k++) begin
            s = rth_pkg::div_step(s);
         end
         stage_in[i] = s;
      end

      always_ff @(posedge clock) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   assign quo = stage_ff[rth_pkg::DIV_STAGES-1].quo;

endmodule

// ===== src/rgb_to_hsl.sv =====
// RGB to HSL converter top level: input register, front end, two dividers, output register.
// One pixel is taken in every clock cycle; busy is always low. Each result passes
// through the input register, two front-end stages, six divider stages of four
// quotient bits each and the output register, and is shown for one cycle
// with rsp_strobe high. The receiver cannot stall, so results must be taken as they come.
// Hue is degrees times 64, saturation and lightness percent times 64, all truncated.
module rgb_to_hsl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rth_pkg::pixel_type  req_data,
   output logic                rsp_strobe,
   output rth_pkg::hsl_type    rsp_data
);

   logic                 in_valid_ff;
   rth_pkg::pixel_type   pixel_ff;
   rth_pkg::ratio_type   ratio;

   logic [rth_pkg::NUM_W-1:0] hue_quo, sat_quo;

   logic [rth_pkg::DIV_STAGES-1:0] valid_ff, valid_in;
   logic [rth_pkg::DIV_STAGES-1:0] grey_ff, grey_in;
   logic [rth_pkg::DIV_STAGES-1:0][12:0] lit_ff, lit_in;

   logic              rsp_strobe_ff;
   rth_pkg::hsl_type  rsp_data_ff, rsp_data_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      pixel_ff <= req_data;
   end

   rth_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .pixel    (pixel_ff),
      .ratio    (ratio)
   );

   rth_div u_hue_div (
      .clock (clock),
      .num   (ratio.hue_num),
      .den   (ratio.hue_den),
      .quo   (hue_quo)
   );

   rth_div u_sat_div (
      .clock (clock),
      .num   (ratio.sat_num),
      .den   (ratio.sat_den),
      .quo   (sat_quo)
   );

   assign valid_in = {valid_ff[rth_pkg::DIV_STAGES-2:0], ratio.valid};
   assign grey_in  = {grey_ff[rth_pkg::DIV_STAGES-2:0], ratio.grey};
   assign lit_in   = {lit_ff[rth_pkg::DIV_STAGES-2:0], ratio.lit};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      grey_ff <= grey_in;
      lit_ff  <= lit_in;
   end

   // grey override and clamps
   always_comb begin
      if (grey_ff[rth_pkg::DIV_STAGES-1]) begin
         rsp_data_in.hue        = '0;
         rsp_data_in.saturation = '0;
      end else begin
         rsp_data_in.hue = (hue_quo > rth_pkg::NUM_W'(rth_pkg::HUE_MAX))
                           ? rth_pkg::HUE_MAX : hue_quo[14:0];
         rsp_data_in.saturation = (sat_quo > rth_pkg::NUM_W'(rth_pkg::PCT_MAX))
                                  ? rth_pkg::PCT_MAX : sat_quo[12:0];
      end
      rsp_data_in.lightness = (lit_ff[rth_pkg::DIV_STAGES-1] > rth_pkg::PCT_MAX)
                              ? rth_pkg::PCT_MAX : lit_ff[rth_pkg::DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_ff[rth_pkg::DIV_STAGES-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== tb/rgb_to_hsl_test.sv =====
// Self-checking testbench for rgb_to_hsl: queued pixel driver, strobe monitor, HSL predictor.
module rgb_to_hsl_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PIXELS = 1000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      rth_pkg::pixel_type px;
      bit                 drain;
   } pixel_job_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   rth_pkg::pixel_type req_data = '0;
   logic               rsp_strobe;
   rth_pkg::hsl_type   rsp_data;

   pixel_job_type    pixels_to_send[$];
   rth_pkg::hsl_type hsl_expected[$];
   int               burst_left = 0;
   int               gap_left = 0;
   int               errors = 0;
   int               cycle_count = 0;

   rgb_to_hsl i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic rth_pkg::hsl_type hsl_of(rth_pkg::pixel_type p);
      int               r, g, b, mx, mn, delta, sum, num, hue, sat, lit;
      rth_pkg::hsl_type h;
      r = int'(p.red);
      g = int'(p.green);
      b = int'(p.blue);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      sum = mx + mn;
      hue = 0;
      sat = 0;
      if (delta != 0) begin
         if (mx == r && g >= b) begin
            num = int'(rth_pkg::DEG60) * (g - b);
         end else if (mx == r) begin
            num = int'(rth_pkg::HUE_BASE_WRAP) * delta - int'(rth_pkg::DEG60) * (b - g);
         end else if (mx == g) begin
            num = int'(rth_pkg::HUE_BASE_GREEN) * delta + int'(rth_pkg::DEG60) * (b - r);
         end else begin
            num = int'(rth_pkg::HUE_BASE_BLUE) * delta + int'(rth_pkg::DEG60) * (r - g);
         end
         if (num < 0) num = 0;
         hue = num / delta;
         if (hue > int'(rth_pkg::HUE_MAX)) hue = int'(rth_pkg::HUE_MAX);
         if (sum <= int'(rth_pkg::SUM_HALF)) begin
            sat = int'(rth_pkg::SAT_SCALE) * delta / sum;
         end else begin
            sat = int'(rth_pkg::SAT_SCALE) * delta / (int'(rth_pkg::SUM_FULL) - sum);
         end
         if (sat > int'(rth_pkg::PCT_MAX)) sat = int'(rth_pkg::PCT_MAX);
      end
      lit = int'(rth_pkg::LIT_SCALE) * sum / int'(rth_pkg::LIT_DIV);
      if (lit > int'(rth_pkg::PCT_MAX)) lit = int'(rth_pkg::PCT_MAX);
      h.hue = 15'(hue);
      h.saturation = 13'(sat);
      h.lightness = 13'(lit);
      return h;
   endfunction

   task automatic add_pixel(int r, int g, int b, bit drain);
      pixel_job_type j;
      j.px.red = 8'(r);
      j.px.green = 8'(g);
      j.px.blue = 8'(b);
      j.drain = drain;
      pixels_to_send.push_back(j);
   endtask

   function automatic int edge_value();
      int v;
      case ($urandom_range(0, 3))
         0: v = 0;
         1: v = 1;
         2: v = 254;
         default: v = 255;
      endcase
      return v;
   endfunction

   // sender: bursts with random gaps; a drain item waits for all results
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            hsl_expected.push_back(hsl_of(pixels_to_send[0].px));
            void'(pixels_to_send.pop_front());
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                          : $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pixels_to_send.size() != 0 &&
                      !(pixels_to_send[0].drain && hsl_expected.size() != 0)) begin
            start <= 1'b1;
            req_data <= pixels_to_send[0].px;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rth_pkg::hsl_type want;
      if (!reset && rsp_strobe) begin
         if (hsl_expected.size() == 0) begin
            $error("unexpected result transfer: hue %0d saturation %0d lightness %0d",
                   rsp_data.hue, rsp_data.saturation, rsp_data.lightness);
            errors++;
         end else begin
            want = hsl_expected.pop_front();
            if (rsp_data.hue !== want.hue) begin
               $error("hue: expected %0d, got %0d", want.hue, rsp_data.hue);
               errors++;
            end
            if (rsp_data.saturation !== want.saturation) begin
               $error("saturation: expected %0d, got %0d", want.saturation,
                      rsp_data.saturation);
               errors++;
            end
            if (rsp_data.lightness !== want.lightness) begin
               $error("lightness: expected %0d, got %0d", want.lightness,
                      rsp_data.lightness);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int r, g, b, v;
      // extremes, primaries, ties, red wraparound, saturation sum boundary
      add_pixel(0, 0, 0, 0);
      add_pixel(255, 255, 255, 0);
      add_pixel(128, 128, 128, 0);
      add_pixel(255, 0, 0, 0);
      add_pixel(0, 255, 0, 0);
      add_pixel(0, 0, 255, 0);
      add_pixel(255, 255, 0, 0);
      add_pixel(255, 0, 255, 0);
      add_pixel(0, 255, 255, 0);
      add_pixel(255, 0, 1, 0);
      add_pixel(255, 1, 0, 0);
      add_pixel(255, 254, 255, 0);
      add_pixel(1, 0, 0, 0);
      add_pixel(0, 1, 0, 0);
      add_pixel(0, 0, 1, 0);
      add_pixel(200, 55, 100, 0);
      add_pixel(200, 56, 100, 0);
      add_pixel(128, 127, 127, 0);
      add_pixel(254, 255, 253, 0);
      add_pixel(85, 170, 255, 0);
      add_pixel(1, 2, 3, 0);
      add_pixel(170, 85, 170, 0);
      add_pixel(10, 200, 199, 0);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               v = $urandom_range(0, 255);
               r = v;
               g = v;
               b = v;
            end
            1: begin
               v = $urandom_range(0, 255);
               r = $urandom_range(0, 255);
               g = $urandom_range(0, 255);
               b = $urandom_range(0, 255);
               case ($urandom_range(0, 2))
                  0: begin r = v; g = v; end
                  1: begin r = v; b = v; end
                  default: begin g = v; b = v; end
               endcase
            end
            2: begin
               r = edge_value();
               g = edge_value();
               b = edge_value();
            end
            default: begin
               r = $urandom_range(0, 255);
               g = $urandom_range(0, 255);
               b = $urandom_range(0, 255);
            end
         endcase
         add_pixel(r, g, b, (i == 0) || ($urandom_range(0, 99) == 0));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pixels_to_send.size() != 0 || hsl_expected.size() != 0 || start)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && hsl_expected.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/rth_pkg.sv
src/rth_front.sv
src/rth_div.sv
src/rgb_to_hsl.sv
tb/rgb_to_hsl_test.sv
